### rtl/core/coap_message_parser_assert.svh
// Assertion helpers shared by the parser modules.
`ifndef COAP_MESSAGE_PARSER_ASSERT_SVH
`define COAP_MESSAGE_PARSER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define COAPMP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("coap parser: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define COAPMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("coap parser: next-cycle check failed");

`endif

### rtl/core/coapmp_pkg.sv
package coapmp_pkg;

  localparam int unsigned MAX_TOKEN = 8;

  typedef enum logic [11:0] {
    PH_HDR     = 12'b0000_0000_0001,
    PH_TOKEN   = 12'b0000_0000_0010,
    PH_HEAD    = 12'b0000_0000_0100,
    PH_DEXT1   = 12'b0000_0000_1000,
    PH_DEXT2A  = 12'b0000_0001_0000,
    PH_DEXT2B  = 12'b0000_0010_0000,
    PH_LEXT1   = 12'b0000_0100_0000,
    PH_LEXT2A  = 12'b0000_1000_0000,
    PH_LEXT2B  = 12'b0001_0000_0000,
    PH_VALUE   = 12'b0010_0000_0000,
    PH_PAYLOAD = 12'b0100_0000_0000,
    PH_IGNORE  = 12'b1000_0000_0000
  } phase_t;

  // byte classes
  localparam logic [3:0] CLS_HEADER    = 4'd0;
  localparam logic [3:0] CLS_TOKEN     = 4'd1;
  localparam logic [3:0] CLS_OPT_HEAD  = 4'd2;
  localparam logic [3:0] CLS_URI_START = 4'd3;
  localparam logic [3:0] CLS_URI_BYTE  = 4'd4;
  localparam logic [3:0] CLS_VALUE     = 4'd5;
  localparam logic [3:0] CLS_MARKER    = 4'd6;
  localparam logic [3:0] CLS_PAYLOAD   = 4'd7;
  localparam logic [3:0] CLS_IGNORED   = 4'd8;

  localparam logic [1:0] VERDICT_NONE  = 2'd0;
  localparam logic [1:0] VERDICT_SERVE = 2'd1;
  localparam logic [1:0] VERDICT_ERROR = 2'd2;
  localparam logic [1:0] VERDICT_DROP  = 2'd3;

  localparam logic [7:0] RESP_NONE        = 8'h00;
  localparam logic [7:0] RESP_BAD_REQUEST = 8'h80;
  localparam logic [7:0] RESP_BAD_OPTION  = 8'h82;
  localparam logic [7:0] RESP_DROP        = 8'hA0;
  localparam logic [7:0] RESP_CHANGED     = 8'h44;

  localparam logic [1:0] TYPE_ACK = 2'd2;
  localparam logic [1:0] TYPE_RST = 2'd3;

  localparam logic [7:0] CODE_EMPTY = 8'h00;
  localparam logic [7:0] CODE_GET   = 8'h01;

  localparam logic [15:0] OPT_OBSERVE  = 16'd6;
  localparam logic [15:0] OPT_URI_PATH = 16'd11;
  localparam logic [15:0] OPT_FORMAT   = 16'd12;

  localparam logic [7:0] MARKER_BYTE = 8'hFF;
  localparam logic [3:0] NIB_EXT1    = 4'd13;
  localparam logic [3:0] NIB_EXT2    = 4'd14;
  localparam logic [3:0] NIB_RSVD    = 4'd15;
  localparam logic [8:0] EXT1_BIAS   = 9'd13;
  localparam logic [16:0] EXT2_BIAS  = 17'd269;
  localparam logic [8:0] URI_MAX     = 9'd511;
  localparam logic [15:0] OPT_MAX    = 16'hFFFF;

  // what the parser hands on for one byte
  typedef struct packed {
    logic [3:0]  cls;
    logic [15:0] option_number;
    logic        done;
    logic        hdr_incomplete;
    logic [31:0] header_fields;
    logic        observe_seen;
    logic [31:0] observe_acc;
    logic [15:0] format_acc;
    logic [7:0]  fault_code;
  } step_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [7:0] response_code;
  } reply_t;

endpackage

### rtl/core/coapmp_parser.sv
module coapmp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          data_byte,
  input  logic                packet_last,
  input  logic [7:0]          uri_limit,
  output coapmp_pkg::step_t   step
);

  coapmp_pkg::phase_t phase, phase_next;
  logic [1:0]  header_count, header_count_next;
  logic [31:0] header_fields, header_fields_next;
  logic [16:0] bytes_left, bytes_left_next;
  logic [15:0] running_option, running_option_next;
  logic [3:0]  pending_length, pending_length_next;
  logic [7:0]  ext_acc, ext_acc_next;
  logic [8:0]  uri_count, uri_count_next;
  logic [31:0] observe_acc, observe_acc_next;
  logic [15:0] format_acc, format_acc_next;
  logic        observe_seen, observe_seen_next;
  logic [7:0]  fault_code, fault_code_next;

  logic [3:0]  cls;
  logic        do_delta, do_begin;
  logic [16:0] delta, len;
  logic [17:0] opt_sum;
  logic [16:0] left_dec;
  logic [3:0]  tkl;

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    header_fields_next  = header_fields;
    bytes_left_next     = bytes_left;
    running_option_next = running_option;
    pending_length_next = pending_length;
    ext_acc_next        = ext_acc;
    uri_count_next      = uri_count;
    observe_acc_next    = observe_acc;
    format_acc_next     = format_acc;
    observe_seen_next   = observe_seen;
    fault_code_next     = fault_code;
    cls      = coapmp_pkg::CLS_IGNORED;
    do_delta = 1'b0;
    do_begin = 1'b0;
    delta    = '0;
    len      = '0;
    opt_sum  = '0;
    tkl      = header_fields[27:24];
    left_dec = (bytes_left != '0) ? bytes_left - 17'd1 : '0;

    unique case (phase)
      coapmp_pkg::PH_HDR: begin
        cls = coapmp_pkg::CLS_HEADER;
        case (header_count)
          2'd0:    header_fields_next[31:24] = data_byte;
          2'd1:    header_fields_next[23:16] = data_byte;
          2'd2:    header_fields_next[15:8]  = data_byte;
          default: header_fields_next[7:0]   = data_byte;
        endcase
        if (header_count == 2'd3) begin
          header_count_next = '0;
          if (32'(tkl) > coapmp_pkg::MAX_TOKEN) begin
            fault_code_next = coapmp_pkg::RESP_BAD_REQUEST;
            phase_next      = coapmp_pkg::PH_IGNORE;
          end else if (tkl != '0) begin
            bytes_left_next = {13'd0, tkl};
            phase_next      = coapmp_pkg::PH_TOKEN;
          end else begin
            phase_next = coapmp_pkg::PH_HEAD;
          end
        end else begin
          header_count_next = header_count + 2'd1;
        end
      end
      coapmp_pkg::PH_TOKEN: begin
        cls             = coapmp_pkg::CLS_TOKEN;
        bytes_left_next = left_dec;
        if (left_dec == '0) phase_next = coapmp_pkg::PH_HEAD;
      end
      coapmp_pkg::PH_HEAD: begin
        if (data_byte == coapmp_pkg::MARKER_BYTE) begin
          cls        = coapmp_pkg::CLS_MARKER;
          phase_next = coapmp_pkg::PH_PAYLOAD;
        end else begin
          cls                 = coapmp_pkg::CLS_OPT_HEAD;
          pending_length_next = data_byte[3:0];
          if (data_byte[7:4] == coapmp_pkg::NIB_RSVD) begin
            fault_code_next = coapmp_pkg::RESP_BAD_OPTION;
            phase_next      = coapmp_pkg::PH_IGNORE;
          end else if (data_byte[7:4] == coapmp_pkg::NIB_EXT1) begin
            phase_next = coapmp_pkg::PH_DEXT1;
          end else if (data_byte[7:4] == coapmp_pkg::NIB_EXT2) begin
            phase_next = coapmp_pkg::PH_DEXT2A;
          end else begin
            do_delta = 1'b1;
            delta    = {13'd0, data_byte[7:4]};
          end
        end
      end
      coapmp_pkg::PH_DEXT1: begin
        cls      = coapmp_pkg::CLS_OPT_HEAD;
        do_delta = 1'b1;
        delta    = {8'd0, {1'b0, data_byte} + coapmp_pkg::EXT1_BIAS};
      end
      coapmp_pkg::PH_DEXT2A: begin
        cls          = coapmp_pkg::CLS_OPT_HEAD;
        ext_acc_next = data_byte;
        phase_next   = coapmp_pkg::PH_DEXT2B;
      end
      coapmp_pkg::PH_DEXT2B: begin
        cls      = coapmp_pkg::CLS_OPT_HEAD;
        do_delta = 1'b1;
        delta    = {1'b0, ext_acc, data_byte} + coapmp_pkg::EXT2_BIAS;
      end
      coapmp_pkg::PH_LEXT1: begin
        cls      = coapmp_pkg::CLS_OPT_HEAD;
        do_begin = 1'b1;
        len      = {8'd0, {1'b0, data_byte} + coapmp_pkg::EXT1_BIAS};
      end
      coapmp_pkg::PH_LEXT2A: begin
        cls          = coapmp_pkg::CLS_OPT_HEAD;
        ext_acc_next = data_byte;
        phase_next   = coapmp_pkg::PH_LEXT2B;
      end
      coapmp_pkg::PH_LEXT2B: begin
        cls      = coapmp_pkg::CLS_OPT_HEAD;
        do_begin = 1'b1;
        len      = {1'b0, ext_acc, data_byte} + coapmp_pkg::EXT2_BIAS;
      end
      coapmp_pkg::PH_VALUE: begin
        if (running_option == coapmp_pkg::OPT_URI_PATH)
          cls = (ext_acc == '0) ? coapmp_pkg::CLS_URI_START
                                : coapmp_pkg::CLS_URI_BYTE;
        else
          cls = coapmp_pkg::CLS_VALUE;
        ext_acc_next = 8'd1;
        if (running_option == coapmp_pkg::OPT_OBSERVE)
          observe_acc_next = {observe_acc[23:0], data_byte};
        else if (running_option == coapmp_pkg::OPT_FORMAT)
          format_acc_next = {format_acc[7:0], data_byte};
        bytes_left_next = left_dec;
        if (left_dec == '0) phase_next = coapmp_pkg::PH_HEAD;
        if (running_option == coapmp_pkg::OPT_URI_PATH) begin
          if (uri_count < coapmp_pkg::URI_MAX) uri_count_next = uri_count + 9'd1;
          if (uri_count_next > {1'b0, uri_limit}) begin
            fault_code_next = coapmp_pkg::RESP_DROP;
            phase_next      = coapmp_pkg::PH_IGNORE;
          end
        end
      end
      coapmp_pkg::PH_PAYLOAD: cls = coapmp_pkg::CLS_PAYLOAD;
      default:                cls = coapmp_pkg::CLS_IGNORED;
    endcase

    // option delta applied; the length nibble seen with it picks what follows
    if (do_delta) begin
      opt_sum = {2'b00, running_option} + {1'b0, delta};
      running_option_next = (opt_sum[17:16] != 2'b00) ? coapmp_pkg::OPT_MAX
                                                       : opt_sum[15:0];
      if (pending_length_next == coapmp_pkg::NIB_EXT1) begin
        phase_next = coapmp_pkg::PH_LEXT1;
      end else if (pending_length_next == coapmp_pkg::NIB_EXT2) begin
        phase_next = coapmp_pkg::PH_LEXT2A;
      end else begin
        do_begin = 1'b1;
        len      = {13'd0, pending_length_next};
      end
    end

    // start of an option value; a Uri-Path segment counts its slash here
    if (do_begin) begin
      if (running_option_next == coapmp_pkg::OPT_URI_PATH &&
          uri_count < coapmp_pkg::URI_MAX)
        uri_count_next = uri_count + 9'd1;
      if (running_option_next == coapmp_pkg::OPT_OBSERVE) begin
        observe_seen_next = 1'b1;
        observe_acc_next  = '0;
      end
      if (running_option_next == coapmp_pkg::OPT_FORMAT) format_acc_next = '0;
      ext_acc_next = '0;
      if (len == '0) begin
        phase_next = coapmp_pkg::PH_HEAD;
      end else begin
        bytes_left_next = len;
        phase_next      = coapmp_pkg::PH_VALUE;
      end
    end
  end

  always_comb begin
    step.cls            = cls;
    step.option_number  = running_option_next;
    step.done           = packet_last;
    step.hdr_incomplete = (phase_next == coapmp_pkg::PH_HDR);
    step.header_fields  = header_fields_next;
    step.observe_seen   = observe_seen_next;
    step.observe_acc    = observe_acc_next;
    step.format_acc     = format_acc_next;
    step.fault_code     = fault_code_next;
  end

  // the last beat of a datagram leaves a clean parse state behind
  always_ff @(posedge clk) begin
    if (rst || (fire && packet_last)) begin
      phase          <= coapmp_pkg::PH_HDR;
      header_count   <= '0;
      header_fields  <= '0;
      bytes_left     <= '0;
      running_option <= '0;
      pending_length <= '0;
      ext_acc        <= '0;
      uri_count      <= '0;
      observe_acc    <= '0;
      format_acc     <= '0;
      observe_seen   <= 1'b0;
      fault_code     <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      header_fields  <= header_fields_next;
      bytes_left     <= bytes_left_next;
      running_option <= running_option_next;
      pending_length <= pending_length_next;
      ext_acc        <= ext_acc_next;
      uri_count      <= uri_count_next;
      observe_acc    <= observe_acc_next;
      format_acc     <= format_acc_next;
      observe_seen   <= observe_seen_next;
      fault_code     <= fault_code_next;
    end
  end

`include "coap_message_parser_assert.svh"

  `COAPMP_ASSERT_NEXT(a_clear_after_last, fire && packet_last,
                      phase == coapmp_pkg::PH_HDR && uri_count == '0 && header_count == '0)
  `COAPMP_ASSERT_NOW(a_hdr_count_phase, header_count != '0, phase == coapmp_pkg::PH_HDR)

endmodule

### rtl/core/coapmp_verdict.sv
module coapmp_verdict (
  input  coapmp_pkg::step_t  step,
  output coapmp_pkg::reply_t reply
);

  logic [1:0] msg_type;
  logic [7:0] code;

  assign msg_type = step.header_fields[29:28];
  assign code     = step.header_fields[23:16];

  // first matching rule wins
  always_comb begin
    if (step.hdr_incomplete) begin
      reply.verdict       = coapmp_pkg::VERDICT_NONE;
      reply.response_code = coapmp_pkg::RESP_NONE;
    end else if (step.fault_code == coapmp_pkg::RESP_DROP) begin
      reply.verdict       = coapmp_pkg::VERDICT_DROP;
      reply.response_code = coapmp_pkg::RESP_DROP;
    end else if (step.fault_code != coapmp_pkg::RESP_NONE) begin
      reply.verdict       = coapmp_pkg::VERDICT_ERROR;
      reply.response_code = step.fault_code;
    end else if (msg_type == coapmp_pkg::TYPE_ACK) begin
      reply.verdict       = coapmp_pkg::VERDICT_NONE;
      reply.response_code = coapmp_pkg::RESP_NONE;
    end else if (msg_type == coapmp_pkg::TYPE_RST) begin
      reply.verdict       = coapmp_pkg::VERDICT_ERROR;
      reply.response_code = coapmp_pkg::RESP_BAD_REQUEST;
    end else if (code == coapmp_pkg::CODE_GET) begin
      reply.verdict       = coapmp_pkg::VERDICT_SERVE;
      reply.response_code = coapmp_pkg::RESP_NONE;
    end else if (code == coapmp_pkg::CODE_EMPTY) begin
      reply.verdict       = coapmp_pkg::VERDICT_NONE;
      reply.response_code = coapmp_pkg::RESP_NONE;
    end else begin
      reply.verdict       = coapmp_pkg::VERDICT_ERROR;
      reply.response_code = coapmp_pkg::RESP_CHANGED;
    end
  end

endmodule

### rtl/core/coap_message_parser.sv
// CoAP datagram parser: one datagram byte per beat on the input channel, one
// result beat per byte on the output channel (byte class and running option
// number always; header summary, Observe and Content-Format values and the
// reply verdict on the beat that carries packet_last, zero otherwise). It
// sustains one byte per clock while out_stall is low, each byte passing the
// input and result registers around the combinational parse step; the parse
// state returns to its reset values after each last byte. The Uri-Path limit
// (reset 64) is written through the always-ready cfg channel, by the user
// only while no datagram is in flight; the block does not enforce this.
module coap_message_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        packet_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  byte_class,
  output logic [15:0] option_number,
  output logic        packet_done,
  output logic [1:0]  msg_type,
  output logic [3:0]  token_length,
  output logic [7:0]  method_code,
  output logic [15:0] message_id,
  output logic        observe_present,
  output logic [31:0] observe_value,
  output logic [15:0] content_format,
  output logic [1:0]  verdict,
  output logic [7:0]  response_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic [7:0] uri_limit;
  logic       in_fire, advance;

  coapmp_pkg::step_t  step;
  coapmp_pkg::reply_t reply;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      uri_limit <= 8'd64;
    end else if (cfg_valid && cfg_ready) begin
      uri_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte <= data_byte;
      s1_last <= packet_last;
    end
  end

  coapmp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .data_byte   (s1_byte),
    .packet_last (s1_last),
    .uri_limit   (uri_limit),
    .step        (step)
  );

  coapmp_verdict u_verdict (
    .step  (step),
    .reply (reply)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // summary fields only carry data on the last beat of a datagram
  always_ff @(posedge clk) begin
    if (advance) begin
      byte_class    <= step.cls;
      option_number <= step.option_number;
      packet_done   <= step.done;
      if (step.done) begin
        msg_type        <= step.header_fields[29:28];
        token_length    <= step.header_fields[27:24];
        method_code     <= step.header_fields[23:16];
        message_id      <= step.header_fields[15:0];
        observe_present <= step.observe_seen;
        observe_value   <= step.observe_acc;
        content_format  <= step.format_acc;
        verdict         <= reply.verdict;
        response_code   <= reply.response_code;
      end else begin
        msg_type        <= '0;
        token_length    <= '0;
        method_code     <= '0;
        message_id      <= '0;
        observe_present <= 1'b0;
        observe_value   <= '0;
        content_format  <= '0;
        verdict         <= coapmp_pkg::VERDICT_NONE;
        response_code   <= coapmp_pkg::RESP_NONE;
      end
    end
  end

`include "coap_message_parser_assert.svh"

  `COAPMP_ASSERT_NOW(a_stall_needs_held_beat, in_stall, s1_valid && out_valid)
  `COAPMP_ASSERT_NOW(a_quiet_mid_packet, out_valid && !packet_done, verdict == coapmp_pkg::VERDICT_NONE && response_code == coapmp_pkg::RESP_NONE)
  `COAPMP_ASSERT_NOW(a_drop_code, out_valid && verdict == coapmp_pkg::VERDICT_DROP, response_code == coapmp_pkg::RESP_DROP)
  `COAPMP_ASSERT_NEXT(a_advance_fills_out, advance, out_valid)

endmodule

### test/tb_coap_message_parser.sv
`timescale 1ns / 1ps

module tb_coap_message_parser;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        packet_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  byte_class;
  logic [15:0] option_number;
  logic        packet_done;
  logic [1:0]  msg_type;
  logic [3:0]  token_length;
  logic [7:0]  method_code;
  logic [15:0] message_id;
  logic        observe_present;
  logic [31:0] observe_value;
  logic [15:0] content_format;
  logic [1:0]  verdict;
  logic [7:0]  response_code;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  coap_message_parser u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .packet_last     (packet_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .byte_class      (byte_class),
    .option_number   (option_number),
    .packet_done     (packet_done),
    .msg_type        (msg_type),
    .token_length    (token_length),
    .method_code     (method_code),
    .message_id      (message_id),
    .observe_present (observe_present),
    .observe_value   (observe_value),
    .content_format  (content_format),
    .verdict         (verdict),
    .response_code   (response_code),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  typedef struct packed {
    logic [3:0]  cls;
    logic [15:0] opt;
    logic        done;
    logic [1:0]  mtype;
    logic [3:0]  tkl;
    logic [7:0]  code;
    logic [15:0] mid;
    logic        obs_p;
    logic [31:0] obs_v;
    logic [15:0] fmt;
    logic [1:0]  verdict;
    logic [7:0]  resp;
  } beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [3:0] cls;
    logic [1:0] verdict;
    logic [7:0] resp;
  } dir_row_t;

  beat_t      beats_due[$];
  logic [7:0] pkt[$];
  dir_row_t   dir_rows [0:23];

  int mismatches = 0;
  int bytes_sent = 0;
  int datagrams  = 0;
  int beats_seen = 0;

  logic quiet    = 1'b0;
  logic hold_go  = 1'b0;
  logic hold_off = 1'b0;

  // parser image
  logic [7:0]          p_lim;
  coapmp_pkg::phase_t  p_phase;
  logic [1:0]          p_hdr_cnt;
  logic [31:0]         p_hdr;
  logic [16:0]         p_left;
  logic [15:0]         p_opt;
  logic [3:0]          p_len;
  logic [15:0]         p_ext;
  logic [8:0]          p_uri;
  logic [31:0]         p_obs;
  logic [15:0]         p_fmt;
  logic                p_obs_seen;
  logic [7:0]          p_err;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void clear_parse();
    p_phase    = coapmp_pkg::PH_HDR;
    p_hdr_cnt  = '0;
    p_hdr      = '0;
    p_left     = '0;
    p_opt      = '0;
    p_len      = '0;
    p_ext      = '0;
    p_uri      = '0;
    p_obs      = '0;
    p_fmt      = '0;
    p_obs_seen = 1'b0;
    p_err      = '0;
  endfunction

  function automatic void start_value(input int unsigned len);
    if (p_opt == coapmp_pkg::OPT_URI_PATH && p_uri < coapmp_pkg::URI_MAX)
      p_uri = p_uri + 1'b1;
    if (p_opt == coapmp_pkg::OPT_OBSERVE) begin
      p_obs_seen = 1'b1;
      p_obs = '0;
    end
    if (p_opt == coapmp_pkg::OPT_FORMAT)
      p_fmt = '0;
    p_ext = '0;
    if (len == 0) begin
      p_phase = coapmp_pkg::PH_HEAD;
    end else begin
      p_left = len[16:0];
      p_phase = coapmp_pkg::PH_VALUE;
    end
  endfunction

  function automatic void apply_delta(input int unsigned d);
    int unsigned sum;
    sum = p_opt + d;
    p_opt = (sum > coapmp_pkg::OPT_MAX) ? coapmp_pkg::OPT_MAX : sum[15:0];
    if (p_len == coapmp_pkg::NIB_EXT1)
      p_phase = coapmp_pkg::PH_LEXT1;
    else if (p_len == coapmp_pkg::NIB_EXT2)
      p_phase = coapmp_pkg::PH_LEXT2A;
    else
      start_value(32'(p_len));
  endfunction

  function automatic beat_t parse_coap_byte(input logic [7:0] b, input logic last);
    beat_t       r;
    logic [3:0]  cls;
    logic [3:0]  dn;
    logic [1:0]  mtype;
    logic [7:0]  code;
    int unsigned v;
    cls = coapmp_pkg::CLS_IGNORED;
    v = 32'(b);
    case (p_phase)
      coapmp_pkg::PH_HDR: begin
        cls = coapmp_pkg::CLS_HEADER;
        p_hdr = p_hdr | ({24'd0, b} << (24 - 8 * p_hdr_cnt));
        if (p_hdr_cnt == 2'd3) begin
          p_hdr_cnt = '0;
          if (32'(p_hdr[27:24]) > coapmp_pkg::MAX_TOKEN) begin
            p_err = coapmp_pkg::RESP_BAD_REQUEST;
            p_phase = coapmp_pkg::PH_IGNORE;
          end else if (p_hdr[27:24] != 4'd0) begin
            p_left = {13'd0, p_hdr[27:24]};
            p_phase = coapmp_pkg::PH_TOKEN;
          end else begin
            p_phase = coapmp_pkg::PH_HEAD;
          end
        end else begin
          p_hdr_cnt = p_hdr_cnt + 1'b1;
        end
      end
      coapmp_pkg::PH_TOKEN: begin
        cls = coapmp_pkg::CLS_TOKEN;
        if (p_left != 0) p_left = p_left - 1'b1;
        if (p_left == 0) p_phase = coapmp_pkg::PH_HEAD;
      end
      coapmp_pkg::PH_HEAD: begin
        if (b == coapmp_pkg::MARKER_BYTE) begin
          cls = coapmp_pkg::CLS_MARKER;
          p_phase = coapmp_pkg::PH_PAYLOAD;
        end else begin
          dn = b[7:4];
          cls = coapmp_pkg::CLS_OPT_HEAD;
          p_len = b[3:0];
          if (dn == coapmp_pkg::NIB_RSVD) begin
            p_err = coapmp_pkg::RESP_BAD_OPTION;
            p_phase = coapmp_pkg::PH_IGNORE;
          end else if (dn == coapmp_pkg::NIB_EXT1) begin
            p_phase = coapmp_pkg::PH_DEXT1;
          end else if (dn == coapmp_pkg::NIB_EXT2) begin
            p_phase = coapmp_pkg::PH_DEXT2A;
          end else begin
            apply_delta(32'(dn));
          end
        end
      end
      coapmp_pkg::PH_DEXT1: begin
        cls = coapmp_pkg::CLS_OPT_HEAD;
        apply_delta(v + coapmp_pkg::EXT1_BIAS);
      end
      coapmp_pkg::PH_DEXT2A: begin
        cls = coapmp_pkg::CLS_OPT_HEAD;
        p_ext = {8'd0, b};
        p_phase = coapmp_pkg::PH_DEXT2B;
      end
      coapmp_pkg::PH_DEXT2B: begin
        cls = coapmp_pkg::CLS_OPT_HEAD;
        v = 32'({p_ext[7:0], b});
        apply_delta(v + coapmp_pkg::EXT2_BIAS);
      end
      coapmp_pkg::PH_LEXT1: begin
        cls = coapmp_pkg::CLS_OPT_HEAD;
        start_value(v + coapmp_pkg::EXT1_BIAS);
      end
      coapmp_pkg::PH_LEXT2A: begin
        cls = coapmp_pkg::CLS_OPT_HEAD;
        p_ext = {8'd0, b};
        p_phase = coapmp_pkg::PH_LEXT2B;
      end
      coapmp_pkg::PH_LEXT2B: begin
        cls = coapmp_pkg::CLS_OPT_HEAD;
        v = 32'({p_ext[7:0], b});
        start_value(v + coapmp_pkg::EXT2_BIAS);
      end
      coapmp_pkg::PH_VALUE: begin
        if (p_opt == coapmp_pkg::OPT_URI_PATH)
          cls = (p_ext == 0) ? coapmp_pkg::CLS_URI_START : coapmp_pkg::CLS_URI_BYTE;
        else
          cls = coapmp_pkg::CLS_VALUE;
        p_ext = 16'd1;
        if (p_opt == coapmp_pkg::OPT_OBSERVE)
          p_obs = {p_obs[23:0], b};
        else if (p_opt == coapmp_pkg::OPT_FORMAT)
          p_fmt = {p_fmt[7:0], b};
        if (p_left != 0) p_left = p_left - 1'b1;
        if (p_left == 0) p_phase = coapmp_pkg::PH_HEAD;
        if (p_opt == coapmp_pkg::OPT_URI_PATH) begin
          if (p_uri < coapmp_pkg::URI_MAX) p_uri = p_uri + 1'b1;
          if (p_uri > {1'b0, p_lim}) begin
            p_err = coapmp_pkg::RESP_DROP;
            p_phase = coapmp_pkg::PH_IGNORE;
          end
        end
      end
      coapmp_pkg::PH_PAYLOAD: cls = coapmp_pkg::CLS_PAYLOAD;
      default: cls = coapmp_pkg::CLS_IGNORED;
    endcase

    r = '0;
    r.cls = cls;
    r.opt = p_opt;
    if (last) begin
      mtype = p_hdr[29:28];
      code  = p_hdr[23:16];
      if (p_phase == coapmp_pkg::PH_HDR) begin
        r.verdict = coapmp_pkg::VERDICT_NONE;  r.resp = coapmp_pkg::RESP_NONE;
      end else if (p_err == coapmp_pkg::RESP_DROP) begin
        r.verdict = coapmp_pkg::VERDICT_DROP;  r.resp = coapmp_pkg::RESP_DROP;
      end else if (p_err != coapmp_pkg::RESP_NONE) begin
        r.verdict = coapmp_pkg::VERDICT_ERROR; r.resp = p_err;
      end else if (mtype == coapmp_pkg::TYPE_ACK) begin
        r.verdict = coapmp_pkg::VERDICT_NONE;  r.resp = coapmp_pkg::RESP_NONE;
      end else if (mtype == coapmp_pkg::TYPE_RST) begin
        r.verdict = coapmp_pkg::VERDICT_ERROR; r.resp = coapmp_pkg::RESP_BAD_REQUEST;
      end else if (code == coapmp_pkg::CODE_GET) begin
        r.verdict = coapmp_pkg::VERDICT_SERVE; r.resp = coapmp_pkg::RESP_NONE;
      end else if (code == coapmp_pkg::CODE_EMPTY) begin
        r.verdict = coapmp_pkg::VERDICT_NONE;  r.resp = coapmp_pkg::RESP_NONE;
      end else begin
        r.verdict = coapmp_pkg::VERDICT_ERROR; r.resp = coapmp_pkg::RESP_CHANGED;
      end
      r.done  = 1'b1;
      r.mtype = mtype;
      r.tkl   = p_hdr[27:24];
      r.code  = code;
      r.mid   = p_hdr[15:0];
      r.obs_p = p_obs_seen;
      r.obs_v = p_obs;
      r.fmt   = p_fmt;
      clear_parse();
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0h want %0h (beat %0d)",
             $realtime, what, got, want, beats_seen);
    mismatches++;
  endtask

  task automatic check_beat();
    beat_t e;
    if (beats_due.size() == 0) begin
      flag_mismatch("unexpected beat", byte_class, 0);
    end else begin
      e = beats_due.pop_front();
      if (byte_class != e.cls)          flag_mismatch("byte_class", byte_class, e.cls);
      if (option_number != e.opt)       flag_mismatch("option_number", option_number, e.opt);
      if (packet_done != e.done)        flag_mismatch("packet_done", packet_done, e.done);
      if (msg_type != e.mtype)          flag_mismatch("msg_type", msg_type, e.mtype);
      if (token_length != e.tkl)        flag_mismatch("token_length", token_length, e.tkl);
      if (method_code != e.code)        flag_mismatch("method_code", method_code, e.code);
      if (message_id != e.mid)          flag_mismatch("message_id", message_id, e.mid);
      if (observe_present != e.obs_p)
        flag_mismatch("observe_present", observe_present, e.obs_p);
      if (observe_value != e.obs_v)     flag_mismatch("observe_value", observe_value, e.obs_v);
      if (content_format != e.fmt)      flag_mismatch("content_format", content_format, e.fmt);
      if (verdict != e.verdict)         flag_mismatch("verdict", verdict, e.verdict);
      if (response_code != e.resp)      flag_mismatch("response_code", response_code, e.resp);
    end
    beats_seen++;
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        check_beat();
      if (stall_left > 0)
        stall_left--;
      else if (!quiet && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 18);
      out_stall <= hold_off || (stall_left > 0);
    end
  end

  initial begin : long_hold
    wait (hold_go);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    packet_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_due.push_back(parse_coap_byte(b, last));
    bytes_sent++;
    if (last) datagrams++;
  endtask

  task automatic set_uri_limit(input logic [7:0] lim);
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    p_lim = lim;
  endtask

  function automatic void push_ext(input int unsigned v);
    if (v >= 269) begin
      pkt.push_back(8'((v - 269) >> 8));
      pkt.push_back(8'((v - 269) & 32'hFF));
    end else if (v >= 13) begin
      pkt.push_back(8'(v - 13));
    end
  endfunction

  function automatic logic [3:0] nib_of(input int unsigned v);
    return (v >= 269) ? coapmp_pkg::NIB_EXT2 : (v >= 13) ? coapmp_pkg::NIB_EXT1 : v[3:0];
  endfunction

  // one datagram: mostly well-formed with random content, some noise,
  // some cut short
  function automatic void build_datagram();
    int unsigned cur, delta, len, opt, r, k, j, n_opt, cut;
    logic [3:0] tkl;
    pkt.delete();
    if ($urandom_range(0, 6) == 0) begin
      n_opt = $urandom_range(1, 12);
      for (k = 0; k < n_opt; k++) pkt.push_back(8'($urandom_range(0, 255)));
      return;
    end
    tkl = 4'(($urandom_range(0, 19) < 17) ? $urandom_range(0, 8) : $urandom_range(9, 15));
    pkt.push_back({2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), tkl});
    r = $urandom_range(0, 9);
    pkt.push_back(8'(r < 5 ? coapmp_pkg::CODE_GET :
                     r < 7 ? coapmp_pkg::CODE_EMPTY : $urandom_range(0, 255)));
    pkt.push_back(8'($urandom_range(0, 255)));
    pkt.push_back(8'($urandom_range(0, 255)));
    for (k = 0; k < tkl; k++) pkt.push_back(8'($urandom_range(0, 255)));
    cur = 0;
    n_opt = $urandom_range(0, 5);
    for (k = 0; k < n_opt; k++) begin
      if ($urandom_range(0, 39) == 0) begin
        // reserved delta nibble, length anything but 15
        pkt.push_back({coapmp_pkg::NIB_RSVD, 4'($urandom_range(0, 14))});
        break;
      end
      r = $urandom_range(0, 19);
      if (r < 6)
        delta = (cur <= coapmp_pkg::OPT_URI_PATH) ? coapmp_pkg::OPT_URI_PATH - cur : 0;
      else if (r < 8)
        delta = (cur <= coapmp_pkg::OPT_OBSERVE) ? coapmp_pkg::OPT_OBSERVE - cur : 0;
      else if (r < 10)
        delta = (cur <= coapmp_pkg::OPT_FORMAT) ? coapmp_pkg::OPT_FORMAT - cur : 0;
      else if (r < 16)  delta = $urandom_range(0, 12);
      else if (r < 18)  delta = $urandom_range(13, 268);
      else if (r == 18) delta = $urandom_range(269, 2000);
      else              delta = $urandom_range(60000, 65804);
      opt = (cur + delta > 65535) ? 65535 : cur + delta;
      if (opt == coapmp_pkg::OPT_URI_PATH)
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      else if (opt == coapmp_pkg::OPT_OBSERVE)
        len = $urandom_range(0, 6);
      else if (opt == coapmp_pkg::OPT_FORMAT)
        len = $urandom_range(0, 3);
      else begin
        r = $urandom_range(0, 39);
        if (r < 32)       len = $urandom_range(0, 4);
        else if (r < 34)  len = 15;
        else if (r < 39)  len = $urandom_range(13, 30);
        else              len = $urandom_range(269, 271);
      end
      pkt.push_back({nib_of(delta), nib_of(len)});
      push_ext(delta);
      push_ext(len);
      for (j = 0; j < len; j++) pkt.push_back(8'($urandom_range(0, 255)));
      cur = opt;
    end
    if ($urandom_range(0, 1) == 1) begin
      pkt.push_back(coapmp_pkg::MARKER_BYTE);
      n_opt = $urandom_range(0, 6);
      for (k = 0; k < n_opt; k++) pkt.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0 && pkt.size() > 1) begin
      cut = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endfunction

  initial begin : stimulus
    int          i, ph, waited, target;
    logic [7:0]  lims [0:3];
    p_lim = 8'd64;
    clear_parse();

    dir_rows[0]  = '{8'h40, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[1]  = '{8'h01, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[2]  = '{8'h12, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[3]  = '{8'h34, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[4]  = '{8'hB1, 1'b0, 1'b0, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[5]  = '{8'h61, 1'b0, 1'b0, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[6]  = '{8'hFF, 1'b0, 1'b0, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[7]  = '{8'h00, 1'b1, 1'b0, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    // reserved delta nibble
    dir_rows[8]  = '{8'h50, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[9]  = '{8'h01, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[10] = '{8'h00, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[11] = '{8'h00, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[12] = '{8'hF0, 1'b0, 1'b1, coapmp_pkg::CLS_OPT_HEAD,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[13] = '{8'h00, 1'b1, 1'b1, coapmp_pkg::CLS_IGNORED,
                     coapmp_pkg::VERDICT_ERROR, coapmp_pkg::RESP_BAD_OPTION};
    // token length 15
    dir_rows[14] = '{8'h4F, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[15] = '{8'h01, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[16] = '{8'hFF, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[17] = '{8'hFF, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[18] = '{8'h00, 1'b1, 1'b1, coapmp_pkg::CLS_IGNORED,
                     coapmp_pkg::VERDICT_ERROR, coapmp_pkg::RESP_BAD_REQUEST};
    // RST, header only
    dir_rows[19] = '{8'h70, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[20] = '{8'h00, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[21] = '{8'h00, 1'b0, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};
    dir_rows[22] = '{8'h00, 1'b1, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_ERROR, coapmp_pkg::RESP_BAD_REQUEST};
    // one-byte datagram, header never completes
    dir_rows[23] = '{8'hFF, 1'b1, 1'b1, coapmp_pkg::CLS_HEADER,
                     coapmp_pkg::VERDICT_NONE, coapmp_pkg::RESP_NONE};

    lims[0] = 8'd255;
    lims[1] = 8'd1;
    lims[2] = 8'($urandom_range(2, 254));
    lims[3] = 8'd16;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < 24; i++) begin
      send_byte(dir_rows[i].data, dir_rows[i].last);
      if (dir_rows[i].typed) begin
        beats_due[beats_due.size() - 1].cls     = dir_rows[i].cls;
        beats_due[beats_due.size() - 1].verdict = dir_rows[i].verdict;
        beats_due[beats_due.size() - 1].resp    = dir_rows[i].resp;
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      set_uri_limit(lims[ph]);
      if (ph == 3) quiet <= 1'b1;
      if (ph == 1) hold_go <= 1'b1;
      target = bytes_sent + 275;
      while (bytes_sent < target) begin
        build_datagram();
        foreach (pkt[k]) send_byte(pkt[k], k == pkt.size() - 1);
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (beats_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (beats_due.size() != 0)
      flag_mismatch("beats never delivered", beats_due.size(), 0);

    $display("%0d bytes in %0d datagrams sent, %0d result beats checked",
             bytes_sent, datagrams, beats_seen);
    $display("Uri-Path limits 64, 255, 1, %0d and 16, one long result hold-off", lims[2]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### coap_message_parser.f
+incdir+rtl/core
rtl/core/coapmp_pkg.sv
rtl/core/coapmp_parser.sv
rtl/core/coapmp_verdict.sv
rtl/core/coap_message_parser.sv
test/tb_coap_message_parser.sv
